@@ sv/lpcsr_pkg.sv @@
// Shared types, widths and codes for the LPC signal restore unit.
package lpcsr_pkg;

   localparam int MAX_ORDER_DEF = 32;
   localparam int COEF_BITS_DEF = 16;

   localparam int CMD_W     = 2;
   localparam int IDX_IN_W  = 5;
   localparam int COEF_IN_W = 16;
   localparam int SAMPLE_W  = 32;
   localparam int ORDER_W   = 6;
   localparam int SHIFT_W   = 5;
   localparam int ACC_W     = 64;
   localparam int PADDR_W   = 3;
   localparam int PDATA_W   = 32;

   localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WARMUP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESTORE = 2'd2;

   localparam logic CSR_ORDER = 1'b0;
   localparam logic CSR_SHIFT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_SHIFT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic op_valid;
   } mac_ctrl_type;

   typedef struct packed {
      logic busy;
   } mac_sts_type;

endpackage

@@ sv/lpcsr_mac.sv @@
// Shared signed multiply-accumulate unit with a registered product stage.
module lpcsr_mac #(
   parameter int COEF_BITS = lpcsr_pkg::COEF_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lpcsr_pkg::mac_ctrl_type               ctrl,
   input  logic signed [lpcsr_pkg::SAMPLE_W-1:0] op_a,
   input  logic signed [COEF_BITS-1:0]           op_b,
   output lpcsr_pkg::mac_sts_type                sts,
   output logic signed [lpcsr_pkg::ACC_W-1:0]    acc
);
   import lpcsr_pkg::*;

   localparam int PROD_W = SAMPLE_W + COEF_BITS;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic                     prod_vld_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_comb begin
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctrl.op_valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign sts.busy = prod_vld_ff;
   assign acc      = acc_ff;

endmodule

@@ sv/lpc_signal_restore_unit.sv @@
// Top level of the LPC signal restore unit: command decode, sequencer, history and CSRs.
// Loading a coefficient or pushing a warm-up sample needs no sequencer state, and the warm-up
// sample appears in the output register on the next cycle. A restore (order capped at
// MAX_ORDER) runs from the accepting cycle through one predictor tap per cycle on the single
// multiply-accumulate unit, a step to close the tap loop, a drain of its pipeline, the
// quantization shift and the final add. With an order of zero no taps are issued and the
// drain finds the pipeline already empty. The input is stalled while a restore is in progress
// and while an unaccepted result blocks the output register, so a waiting result delays the
// next transaction. The registers filter_order (byte address 0) and quant_shift (byte address 4)
// are written and read through the APB port.
module lpc_signal_restore_unit #(
   parameter int MAX_ORDER = lpcsr_pkg::MAX_ORDER_DEF,
   parameter int COEF_BITS = lpcsr_pkg::COEF_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [lpcsr_pkg::CMD_W-1:0]            req_cmd,
   input  logic [lpcsr_pkg::IDX_IN_W-1:0]         req_coef_index,
   input  logic signed [lpcsr_pkg::COEF_IN_W-1:0] req_coef_value,
   input  logic signed [lpcsr_pkg::SAMPLE_W-1:0]  req_residual,
   input  logic                                   req_end_of_block,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [lpcsr_pkg::SAMPLE_W-1:0]  rsp_sample,
   output logic signed [lpcsr_pkg::SAMPLE_W-1:0]  rsp_prediction,
   output logic                                   rsp_block_end,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [lpcsr_pkg::PADDR_W-1:0]          paddr,
   input  logic [lpcsr_pkg::PDATA_W-1:0]          pwdata,
   output logic [lpcsr_pkg::PDATA_W-1:0]          prdata,
   output logic                                   pready
);
   import lpcsr_pkg::*;

   localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int CNT_W = $clog2(MAX_ORDER + 1);

   state_type state_ff;
   state_type state_in;

   logic [ORDER_W-1:0] filter_order_ff;
   logic [SHIFT_W-1:0] quant_shift_ff;
   logic [ORDER_W-1:0] order_eff;
   logic               csr_write;

   logic                 accept;
   logic                 out_free;
   logic                 start_restore;
   logic                 coef_we;
   logic                 issue;
   logic                 push;
   logic                 cnt_below;
   logic [CNT_W-1:0]     cnt_ff;
   logic [CNT_W-1:0]     cnt_in;
   logic                 op_vld_ff;

   logic signed [COEF_BITS-1:0] coef_mem_ff [MAX_ORDER];
   logic signed [COEF_BITS-1:0] coef_rd_ff;
   logic signed [COEF_BITS-1:0] coef_wdata;
   logic signed [SAMPLE_W-1:0]  hist_ff [MAX_ORDER];
   logic signed [SAMPLE_W-1:0]  op_a_ff;

   mac_ctrl_type               mac_ctrl;
   mac_sts_type                mac_sts;
   logic signed [ACC_W-1:0]    mac_acc;
   logic signed [ACC_W-1:0]    acc_shifted;
   logic signed [SAMPLE_W-1:0] pred_ff;
   logic signed [SAMPLE_W-1:0] res_ff;
   logic                       eob_ff;
   logic signed [SAMPLE_W-1:0] push_value;

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic signed [SAMPLE_W-1:0] rsp_prediction_ff;
   logic                       rsp_block_end_ff;

   // Configuration port.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_order_ff <= ORDER_W'(1);
         quant_shift_ff  <= '0;
      end else if (csr_write) begin
         unique case (paddr[2])
            CSR_ORDER: filter_order_ff <= pwdata[ORDER_W-1:0];
            CSR_SHIFT: quant_shift_ff  <= pwdata[SHIFT_W-1:0];
            default:   ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         CSR_ORDER: prdata = PDATA_W'(filter_order_ff);
         CSR_SHIFT: prdata = PDATA_W'(quant_shift_ff);
         default:   prdata = '0;
      endcase
   end

   assign order_eff = (filter_order_ff > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER)
                                                              : filter_order_ff;

   // Handshake.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign cnt_below = ORDER_W'(cnt_ff) < order_eff;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == CMD_RESTORE)) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (!cnt_below) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!op_vld_ff && !mac_sts.busy) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      start_restore = 1'b0;
      coef_we       = 1'b0;
      issue         = 1'b0;
      push          = 1'b0;
      push_value    = req_residual;
      unique case (state_ff)
         ST_IDLE: begin
            start_restore = accept && (req_cmd == CMD_RESTORE);
            coef_we       = accept && (req_cmd == CMD_LOAD)
                            && ({1'b0, req_coef_index} < ORDER_W'(MAX_ORDER));
            push          = accept && (req_cmd == CMD_WARMUP);
         end
         ST_MAC: issue = cnt_below;
         ST_DRAIN, ST_SHIFT: ;
         ST_EMIT: begin
            push       = out_free;
            push_value = res_ff + pred_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Tap counter and operand fetch.
   always_comb begin
      if (start_restore) begin
         cnt_in = '0;
      end else if (issue) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         op_vld_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         op_vld_ff <= issue;
      end
   end

   assign coef_wdata = COEF_BITS'(req_coef_value);

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem_ff[req_coef_index[IDX_W-1:0]] <= coef_wdata;
      end
      if (issue) begin
         coef_rd_ff <= coef_mem_ff[cnt_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         op_a_ff <= hist_ff[cnt_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_ORDER; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (push) begin
         for (int i = 1; i < MAX_ORDER; i++) begin
            hist_ff[i] <= hist_ff[i-1];
         end
         hist_ff[0] <= push_value;
      end
   end

   assign mac_ctrl.clear    = start_restore;
   assign mac_ctrl.op_valid = op_vld_ff;

   lpcsr_mac #(
      .COEF_BITS(COEF_BITS)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .op_a  (op_a_ff),
      .op_b  (coef_rd_ff),
      .sts   (mac_sts),
      .acc   (mac_acc)
   );

   assign acc_shifted = mac_acc >>> quant_shift_ff;

   always_ff @(posedge clock) begin
      if (start_restore) begin
         res_ff <= req_residual;
         eob_ff <= req_end_of_block;
      end
      if (state_ff == ST_SHIFT) begin
         pred_ff <= acc_shifted[SAMPLE_W-1:0];
      end
   end

   // Output register.
   always_comb begin
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_sample_ff <= push_value;
         if (state_ff == ST_EMIT) begin
            rsp_prediction_ff <= pred_ff;
            rsp_block_end_ff  <= eob_ff;
         end else begin
            rsp_prediction_ff <= '0;
            rsp_block_end_ff  <= req_end_of_block;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample     = rsp_sample_ff;
   assign rsp_prediction = rsp_prediction_ff;
   assign rsp_block_end  = rsp_block_end_ff;

   // A new result only ever comes from a warm-up transaction or the end of a restore.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |->
         $past(accept && (req_cmd == CMD_WARMUP)) || $past((state_ff == ST_EMIT) && out_free))
      else $error("result appeared without a warm-up or restore transaction");

   // The quantization shift only sees a fully drained accumulator.
   a_shift_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (!op_vld_ff && !mac_sts.busy))
      else $error("shift started with taps still in the multiply pipeline");

   // The tap counter never runs past the effective filter order.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> (ORDER_W'(cnt_ff) <= order_eff))
      else $error("tap counter ran past the filter order");

   // A warm-up transaction yields a result with zero prediction on the next cycle.
   a_warmup_pred: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd == CMD_WARMUP)) |=> (rsp_valid_ff && (rsp_prediction_ff == '0)))
      else $error("warm-up result missing or has a nonzero prediction");

   // History does not move while a prediction is being accumulated.
   a_hist_hold: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_MAC) || (state_ff == ST_DRAIN)) |-> !push)
      else $error("history shifted during a restore");

endmodule

@@ test/lpc_signal_restore_unit_test.sv @@
// Self-checking testbench for the LPC signal restore unit with an in-bench sample predictor.
`timescale 1ns / 100ps

module lpc_signal_restore_unit_test;
   import lpcsr_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 11;
   localparam int MAX_ORDER = MAX_ORDER_DEF;
   localparam int IDLE_PERCENT = 34;
   localparam int RANDOM_ITEMS = 1150;
   localparam int SETTLE_CYCLES = MAX_ORDER + 16;
   localparam int CYCLE_LIMIT = 800000;
   localparam int MAX_REPORTS = 200;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic [PADDR_W-1:0] ADDR_FILTER_ORDER = 3'd0;
   localparam logic [PADDR_W-1:0] ADDR_QUANT_SHIFT = 3'd4;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [SAMPLE_W-1:0] prediction;
      logic block_end;
   } sample_result_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [CMD_W-1:0] req_cmd;
   logic [IDX_IN_W-1:0] req_coef_index;
   logic signed [COEF_IN_W-1:0] req_coef_value;
   logic signed [SAMPLE_W-1:0] req_residual;
   logic req_end_of_block;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample;
   logic signed [SAMPLE_W-1:0] rsp_prediction;
   logic rsp_block_end;
   logic psel;
   logic penable;
   logic pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic pready;

   logic signed [SAMPLE_W-1:0] history_model [MAX_ORDER];
   logic signed [COEF_IN_W-1:0] coef_model [MAX_ORDER];
   logic [MAX_ORDER-1:0] coef_loaded;
   logic [ORDER_W-1:0] order_model;
   logic [SHIFT_W-1:0] shift_model;

   sample_result_type pending_samples [$];
   sample_result_type expected_result;
   int mismatches = 0;
   int items_sent = 0;
   int cycle_count = 0;
   bit gaps_on = 1'b1;

   lpc_signal_restore_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_coef_index   (req_coef_index),
      .req_coef_value   (req_coef_value),
      .req_residual     (req_residual),
      .req_end_of_block (req_end_of_block),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample       (rsp_sample),
      .rsp_prediction   (rsp_prediction),
      .rsp_block_end    (rsp_block_end),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= gaps_on && ($urandom_range(99) < IDLE_PERCENT);
   end

   function automatic void push_history(input logic signed [SAMPLE_W-1:0] value);
      int k;
      for (k = MAX_ORDER - 1; k > 0; k--) history_model[k] = history_model[k - 1];
      history_model[0] = value;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] predict_restore();
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] coef_wide;
      logic signed [ACC_W-1:0] sample_wide;
      int taps;
      int j;
      acc = '0;
      taps = (order_model > MAX_ORDER) ? MAX_ORDER : int'(order_model);
      for (j = 0; j < taps; j++) begin
         coef_wide = coef_model[j];
         sample_wide = history_model[j];
         acc = acc + coef_wide * sample_wide;
      end
      acc = acc >>> shift_model;
      return acc[SAMPLE_W-1:0];
   endfunction

   function automatic logic signed [COEF_IN_W-1:0] random_coef();
      case ($urandom_range(9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2, 3, 4, 5: return 16'($urandom_range(4095)) - 16'd2048;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_residual();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0;
         3, 4: return 32'($urandom_range(1023)) - 32'd512;
         default: return 32'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] expected,
                                  input logic [31:0] actual);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, expected, actual);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected result, expected none, actual sample %h", $time,
                        rsp_sample);
         end else begin
            expected_result = pending_samples.pop_front();
            if (rsp_sample !== expected_result.sample)
               report_mismatch("sample", expected_result.sample, rsp_sample);
            if (rsp_prediction !== expected_result.prediction)
               report_mismatch("prediction", expected_result.prediction, rsp_prediction);
            if (rsp_block_end !== expected_result.block_end)
               report_mismatch("block_end", 32'(expected_result.block_end), 32'(rsp_block_end));
         end
      end
   end

   task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [IDX_IN_W-1:0] index,
                                input logic signed [COEF_IN_W-1:0] coef,
                                input logic signed [SAMPLE_W-1:0] residual, input logic eob);
      sample_result_type result;
      while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_coef_index <= index;
      req_coef_value <= coef;
      req_residual <= residual;
      req_end_of_block <= eob;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      result.block_end = eob;
      case (cmd)
         CMD_LOAD: begin
            coef_model[index] = coef;
            coef_loaded[index] = 1'b1;
         end
         CMD_WARMUP: begin
            push_history(residual);
            result.sample = residual;
            result.prediction = '0;
            pending_samples.push_back(result);
         end
         CMD_RESTORE: begin
            result.prediction = predict_restore();
            result.sample = residual + result.prediction;
            push_history(result.sample);
            pending_samples.push_back(result);
         end
         default: ;
      endcase
      if (cmd != CMD_UNUSED) items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      if (addr == ADDR_FILTER_ORDER) order_model = data[ORDER_W-1:0];
      else shift_model = data[SHIFT_W-1:0];
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input int order_value, input int shift_value);
      logic [PDATA_W-1:0] upper;
      wait_idle();
      upper = $urandom;
      write_register(ADDR_FILTER_ORDER, {upper[PDATA_W-1:ORDER_W], ORDER_W'(order_value)});
      upper = $urandom;
      write_register(ADDR_QUANT_SHIFT, {upper[PDATA_W-1:SHIFT_W], SHIFT_W'(shift_value)});
   endtask

   task automatic test_reset_defaults();
      issue_command(CMD_LOAD, 5'd0, 16'sh7fff, 32'h0, 1'b0);
      issue_command(CMD_RESTORE, 5'd0, 16'sh0, 32'sd123, 1'b0);
      issue_command(CMD_WARMUP, 5'd31, 16'sh8000, 32'h8000_0000, 1'b0);
      issue_command(CMD_RESTORE, 5'd0, 16'sh0, 32'h7fff_ffff, 1'b1);
      issue_command(CMD_UNUSED, 5'd31, 16'sh7fff, 32'hffff_ffff, 1'b1);
      issue_command(CMD_RESTORE, 5'd7, 16'sh1234, 32'h0, 1'b0);
   endtask

   task automatic test_coefficient_extremes();
      set_config(2, 0);
      issue_command(CMD_LOAD, 5'd0, 16'sh8000, 32'hffff_ffff, 1'b1);
      issue_command(CMD_LOAD, 5'd1, 16'sh7fff, 32'h0, 1'b0);
      issue_command(CMD_LOAD, 5'd31, 16'sh5555, 32'h5555_5555, 1'b0);
      issue_command(CMD_LOAD, 5'd21, 16'shaaaa, 32'haaaa_aaaa, 1'b1);
      issue_command(CMD_WARMUP, 5'd0, 16'sh0, 32'h7fff_ffff, 1'b0);
      issue_command(CMD_WARMUP, 5'd0, 16'sh0, 32'h8000_0000, 1'b1);
      issue_command(CMD_RESTORE, 5'd0, 16'sh0, 32'h7fff_ffff, 1'b0);
      issue_command(CMD_RESTORE, 5'd0, 16'sh0, 32'h8000_0000, 1'b0);
      set_config(2, 31);
      issue_command(CMD_RESTORE, 5'd0, 16'sh0, 32'hffff_ffff, 1'b1);
      issue_command(CMD_RESTORE, 5'd0, 16'sh0, 32'h0, 1'b0);
   endtask

   task automatic test_order_zero();
      set_config(0, 31);
      issue_command(CMD_RESTORE, 5'd3, 16'sh7fff, 32'hffff_ffff, 1'b0);
      issue_command(CMD_WARMUP, 5'd0, 16'sh0, 32'h1234_5678, 1'b1);
      issue_command(CMD_UNUSED, 5'd0, 16'sh8000, 32'h8000_0000, 1'b0);
      issue_command(CMD_RESTORE, 5'd0, 16'sh0, 32'h8000_0000, 1'b1);
   endtask

   task automatic run_block(input int order_value, input int shift_value, input int restores,
                            input bit well_formed);
      int taps;
      int warmups;
      int i;
      set_config(order_value, shift_value);
      taps = (order_value > MAX_ORDER) ? MAX_ORDER : order_value;
      for (i = 0; i < taps; i++)
         if (well_formed || !coef_loaded[i] || $urandom_range(1))
            issue_command(CMD_LOAD, IDX_IN_W'(i), random_coef(), random_residual(),
                          1'($urandom));
      warmups = well_formed ? taps : $urandom_range(taps);
      for (i = 0; i < warmups; i++)
         issue_command(CMD_WARMUP, IDX_IN_W'($urandom), 16'($urandom), random_residual(),
                       $urandom_range(15) == 0);
      for (i = 0; i < restores; i++) begin
         case ($urandom_range(19))
            0: issue_command(CMD_UNUSED, IDX_IN_W'($urandom), 16'($urandom), 32'($urandom),
                             1'($urandom));
            1: issue_command(CMD_LOAD, IDX_IN_W'($urandom), random_coef(), 32'($urandom),
                             1'($urandom));
            default: ;
         endcase
         issue_command(CMD_RESTORE, IDX_IN_W'($urandom), 16'($urandom), random_residual(),
                       (i == restores - 1) ? (well_formed || 1'($urandom))
                                           : ($urandom_range(15) == 0));
      end
   endtask

   task automatic test_random_blocks();
      int start_count;
      int block_count;
      int order_value;
      int shift_value;
      start_count = items_sent;
      block_count = 0;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         gaps_on = !((items_sent - start_count) >= 400 && (items_sent - start_count) < 650);
         case (block_count)
            0: begin order_value = 63; shift_value = 31; end
            1: begin order_value = 32; shift_value = 0; end
            2: begin order_value = 0; shift_value = 7; end
            3: begin order_value = 1; shift_value = 31; end
            4: begin order_value = 33; shift_value = 12; end
            default: begin
               case ($urandom_range(9))
                  0: order_value = 0;
                  1: order_value = $urandom_range(63, 33);
                  2, 3: order_value = $urandom_range(32, 9);
                  default: order_value = $urandom_range(8, 1);
               endcase
               shift_value = $urandom_range(31);
            end
         endcase
         run_block(order_value, shift_value, $urandom_range(40, 4), $urandom_range(9) != 0);
         block_count++;
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      int i;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= CMD_UNUSED;
      req_coef_index <= '0;
      req_coef_value <= '0;
      req_residual <= '0;
      req_end_of_block <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      for (i = 0; i < MAX_ORDER; i++) begin
         history_model[i] = '0;
         coef_model[i] = '0;
      end
      coef_loaded = '0;
      order_model = ORDER_W'(1);
      shift_model = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_coefficient_extremes();
      test_order_zero();
      test_random_blocks();
      wait_idle();
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
